[src/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the Unix time to calendar core
// Widths, calendar constants, reciprocal factors and pipeline control types.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Beat widths
  localparam int unsigned TS_W        = 39;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 1;

  // Pipeline depth
  localparam int unsigned NSTAGE = 14;

  // Valid span and shift to 0001-01-01 00:00:00
  localparam logic signed [TS_W-1:0] TS_MIN    = -39'sd62135596800;
  localparam logic signed [TS_W-1:0] TS_MAX    = 39'sd253402300799;
  localparam logic [TS_W-1:0]        EPOCH_OFS = 39'd62135596800;

  // Seconds per day is 2^7 * 675
  localparam int unsigned DAY_LO_W  = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned REC_DAY   = 407226528;   // floor(2^38 / 675)
  localparam int unsigned REC_DAY_SH = 38;

  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;
  localparam int unsigned DAYS_JAN_FEB = 59;
  localparam int unsigned DAYS_MAR_DEC = 306;
  localparam int unsigned SECS_HOUR = 3600;
  localparam int unsigned SECS_MIN  = 60;

  // floor(2^s / d), s = width of the dividend
  localparam int unsigned REC_400Y = 28;   // s = 22
  localparam int unsigned REC_100Y = 7;    // s = 18
  localparam int unsigned REC_4Y   = 44;   // s = 16
  localparam int unsigned REC_1Y   = 5;    // s = 11
  localparam int unsigned REC_HOUR = 36;   // s = 17
  localparam int unsigned REC_MIN  = 68;   // s = 12

  localparam int unsigned MONTHS = 12;

  typedef struct packed {
    logic [NSTAGE-1:0] en;    // stage load enable
    logic [NSTAGE-1:0] vld;   // stage holds a live beat
  } pipe_ctl_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // First day of each month in a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[src/epoch_seconds_to_calendar_core.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: Unix seconds to Gregorian date and time
// Fourteen-stage pipeline; constant divisions by reciprocal estimate plus
// one correction step each.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+------------
//  in_     | in  | timestamp[38:0] signed, bit 39 zero             | -
//  out_    | out | year[13:0] month[17:14] day_of_month[22:18]     | range_error
//          |     | hour[27:23] minute[33:28] second[39:34]         |
//
//  Throughput is one beat per cycle unless the output stalls with every stage full.
//  The depth is set by the constant divisions (day, era, century, 4-year block,
//  year), each an estimate and a correction stage, plus a back-multiply for day.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  A stalled output holds; earlier stages keep moving into empty slots, so
//  in_tready stays high while any stage is empty or out_tready is high.
//
module epoch_seconds_to_calendar_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [esc_pkg::IN_TDATA_W-1:0]  in_tdata,   // timestamp
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [esc_pkg::OUT_TDATA_W-1:0] out_tdata,  // year, month, day_of_month,
                                                      // hour, minute, second
  output logic [esc_pkg::OUT_TUSER_W-1:0] out_tuser   // range_error
);
  import esc_pkg::*;

  pipe_ctl_t ctl;

  esc_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] err_r;              // out-of-range flag, travels along

  logic [TS_W-1:0]   s0_u_r;             // seconds since 0001-01-01
  logic [31:0]       s1_q0_r, s2_q0_r;   // seconds / 128
  logic [6:0]        s1_lo_r, s2_lo_r;   // seconds % 128
  logic [22:0]       s1_qe_r, s2_qe_r;   // estimate of (seconds/128)/675
  logic [31:0]       s2_qd_r;            // estimate * 675
  logic [21:0]       s3_days_r, s4_days_r;
  logic [16:0]       s3_sod_r, s4_sod_r;
  logic [4:0]        s4_era_e_r, s4_hr_e_r;
  logic [4:0]        era_r [5:NSTAGE-3];
  logic [17:0]       s5_doe_r, s6_doe_r;
  logic [4:0]        s5_hour_r, s6_hour_r;
  logic [11:0]       s5_sos_r, s6_sos_r;
  logic [2:0]        s6_cent_e_r;
  logic [5:0]        s6_min_e_r;
  logic [1:0]        cent_r [7:NSTAGE-3];
  logic [15:0]       s7_doc_r, s8_doc_r;
  tod_t              tod_r  [7:NSTAGE-1];
  logic [4:0]        s8_blk_e_r;
  logic [4:0]        blk_r  [9:NSTAGE-3];
  logic [10:0]       s9_dob_r, s10_dob_r;
  logic [2:0]        s10_yob_e_r;
  logic [1:0]        s11_yob_r;
  logic [8:0]        s11_doy_r;
  logic [13:0]       s12_year_r, s13_year_r;
  logic [8:0]        s12_doy_r;
  logic [3:0]        s13_month_r;
  logic [4:0]        s13_day_r;

  // --------------------------------------------------------------------------
  // Next-state logic, one block per stage
  // --------------------------------------------------------------------------
  logic signed [TS_W-1:0] ts;
  logic [TS_W-1:0] s0_u_nxt;
  logic            s0_err_nxt;

  // Stage 0: shift origin to year 1, range check
  always_comb begin
    ts         = $signed(in_tdata[TS_W-1:0]);
    s0_err_nxt = (ts < TS_MIN) || (ts > TS_MAX);
    s0_u_nxt   = $unsigned(ts) + EPOCH_OFS;
  end

  // Stage 1: 86400 = 128 * 675; quotient estimate by reciprocal, low by 1 at most
  logic [60:0] s1_prod;
  logic [22:0] s1_qe_nxt;
  always_comb begin
    s1_prod   = 61'(s0_u_r[TS_W-1:DAY_LO_W]) * 61'(REC_DAY);
    s1_qe_nxt = s1_prod[60:REC_DAY_SH];
  end

  // Stage 2: back-multiply
  logic [31:0] s2_qd_nxt;
  assign s2_qd_nxt = 32'(s1_qe_r) * 32'(DAY_ODD);

  // Stage 3: remainder and correction -> day number and second of day
  logic [31:0] s3_rw;
  logic [10:0] s3_r;
  logic        s3_fix;
  logic [22:0] s3_q;
  logic [9:0]  s3_rr;
  logic [21:0] s3_days_nxt;
  logic [16:0] s3_sod_nxt;
  always_comb begin
    s3_rw       = s2_q0_r - s2_qd_r;
    s3_r        = s3_rw[10:0];
    s3_fix      = s3_r >= 11'(DAY_ODD);
    s3_q        = s2_qe_r + 23'(s3_fix);
    s3_rr       = s3_fix ? 10'(s3_r - 11'(DAY_ODD)) : s3_r[9:0];
    s3_days_nxt = s3_q[21:0];
    s3_sod_nxt  = {s3_rr, s2_lo_r};
  end

  // Stage 4: era and hour estimates
  logic [26:0] s4_pe;
  logic [22:0] s4_ph;
  logic [4:0]  s4_era_e_nxt, s4_hr_e_nxt;
  always_comb begin
    s4_pe        = 27'(s3_days_r) * 27'(REC_400Y);
    s4_ph        = 23'(s3_sod_r) * 23'(REC_HOUR);
    s4_era_e_nxt = s4_pe[26:22];
    s4_hr_e_nxt  = s4_ph[21:17];
  end

  // Stage 5: correct era / day of era, hour / second of hour
  logic [21:0] s5_t;
  logic        s5_efix;
  logic [16:0] s5_th;
  logic        s5_hfix;
  logic [4:0]  s5_era_nxt, s5_hour_nxt;
  logic [17:0] s5_doe_nxt;
  logic [11:0] s5_sos_nxt;
  always_comb begin
    s5_t        = s4_days_r - 22'(s4_era_e_r) * 22'(DAYS_400Y);
    s5_efix     = s5_t >= 22'(DAYS_400Y);
    s5_era_nxt  = s4_era_e_r + 5'(s5_efix);
    s5_doe_nxt  = s5_efix ? 18'(s5_t - 22'(DAYS_400Y)) : s5_t[17:0];
    s5_th       = s4_sod_r - 17'(s4_hr_e_r) * 17'(SECS_HOUR);
    s5_hfix     = s5_th >= 17'(SECS_HOUR);
    s5_hour_nxt = s4_hr_e_r + 5'(s5_hfix);
    s5_sos_nxt  = s5_hfix ? 12'(s5_th - 17'(SECS_HOUR)) : s5_th[11:0];
  end

  // Stage 6: century and minute estimates
  logic [20:0] s6_pc;
  logic [18:0] s6_pm;
  logic [2:0]  s6_cent_e_nxt;
  logic [5:0]  s6_min_e_nxt;
  always_comb begin
    s6_pc         = 21'(s5_doe_r) * 21'(REC_100Y);
    s6_pm         = 19'(s5_sos_r) * 19'(REC_MIN);
    s6_cent_e_nxt = s6_pc[20:18];
    s6_min_e_nxt  = s6_pm[17:12];
  end

  // Stage 7: correct century and minute; last day of an era stays in century 3
  logic [17:0] s7_t;
  logic        s7_cfix;
  logic [2:0]  s7_cent;
  logic [15:0] s7_doc;
  logic [11:0] s7_tm;
  logic        s7_mfix;
  logic [1:0]  s7_cent_nxt;
  logic [15:0] s7_doc_nxt;
  tod_t        s7_tod_nxt;
  always_comb begin
    s7_t    = s6_doe_r - 18'(s6_cent_e_r) * 18'(DAYS_100Y);
    s7_cfix = s7_t >= 18'(DAYS_100Y);
    s7_cent = s6_cent_e_r + 3'(s7_cfix);
    s7_doc  = s7_cfix ? 16'(s7_t - 18'(DAYS_100Y)) : s7_t[15:0];
    if (s7_cent == 3'd4) begin
      s7_cent_nxt = 2'd3;
      s7_doc_nxt  = 16'(DAYS_100Y);
    end else begin
      s7_cent_nxt = s7_cent[1:0];
      s7_doc_nxt  = s7_doc;
    end
    s7_tm             = s6_sos_r - 12'(s6_min_e_r) * 12'(SECS_MIN);
    s7_mfix           = s7_tm >= 12'(SECS_MIN);
    s7_tod_nxt.hour   = s6_hour_r;
    s7_tod_nxt.minute = s6_min_e_r + 6'(s7_mfix);
    s7_tod_nxt.second = s7_mfix ? 6'(s7_tm - 12'(SECS_MIN)) : s7_tm[5:0];
  end

  // Stage 8: 4-year block estimate
  logic [21:0] s8_pb;
  logic [4:0]  s8_blk_e_nxt;
  always_comb begin
    s8_pb        = 22'(s7_doc_r) * 22'(REC_4Y);
    s8_blk_e_nxt = s8_pb[20:16];
  end

  // Stage 9: correct block / day of block
  logic [15:0] s9_t;
  logic        s9_fix;
  logic [4:0]  s9_blk_nxt;
  logic [10:0] s9_dob_nxt;
  always_comb begin
    s9_t       = s8_doc_r - 16'(s8_blk_e_r) * 16'(DAYS_4Y);
    s9_fix     = s9_t >= 16'(DAYS_4Y);
    s9_blk_nxt = s8_blk_e_r + 5'(s9_fix);
    s9_dob_nxt = s9_fix ? 11'(s9_t - 16'(DAYS_4Y)) : s9_t[10:0];
  end

  // Stage 10: year-of-block estimate
  logic [13:0] s10_py;
  logic [2:0]  s10_yob_e_nxt;
  always_comb begin
    s10_py        = 14'(s9_dob_r) * 14'(REC_1Y);
    s10_yob_e_nxt = s10_py[13:11];
  end

  // Stage 11: correct year; last day of a block stays in year 3
  logic [10:0] s11_t;
  logic        s11_fix;
  logic [2:0]  s11_yob;
  logic [8:0]  s11_doy;
  logic [1:0]  s11_yob_nxt;
  logic [8:0]  s11_doy_nxt;
  always_comb begin
    s11_t   = s10_dob_r - 11'(s10_yob_e_r) * 11'(DAYS_1Y);
    s11_fix = s11_t >= 11'(DAYS_1Y);
    s11_yob = s10_yob_e_r + 3'(s11_fix);
    s11_doy = s11_fix ? 9'(s11_t - 11'(DAYS_1Y)) : s11_t[8:0];
    if (s11_yob == 3'd4) begin
      s11_yob_nxt = 2'd3;
      s11_doy_nxt = 9'(DAYS_1Y);
    end else begin
      s11_yob_nxt = s11_yob[1:0];
      s11_doy_nxt = s11_doy;
    end
  end

  // Stage 12: assemble year; leap status follows from the split directly
  // (year % 4 == 0 iff yob is 3, % 100 iff also block 24, % 400 iff also
  // century 3). Rebase day of year to March 1.
  logic        s12_leap;
  logic [8:0]  s12_janfeb;
  logic [13:0] s12_year_nxt;
  logic [8:0]  s12_doy_nxt;
  always_comb begin
    s12_year_nxt = 14'd1 + 14'(s11_yob_r) + 14'(blk_r[11]) * 14'd4
                 + 14'(cent_r[11]) * 14'd100 + 14'(era_r[11]) * 14'd400;
    s12_leap     = (s11_yob_r == 2'd3) && ((blk_r[11] != 5'd24) || (cent_r[11] == 2'd3));
    s12_janfeb   = 9'(DAYS_JAN_FEB) + 9'(s12_leap);
    if (s11_doy_r >= s12_janfeb) begin
      s12_doy_nxt = s11_doy_r - s12_janfeb;
    end else begin
      s12_doy_nxt = s11_doy_r + 9'(DAYS_MAR_DEC);
    end
  end

  // Stage 13: month by compare against month starts, then day; zero on error
  logic [3:0]  s13_mi;
  logic [8:0]  s13_dd;
  logic [3:0]  s13_month_nxt;
  logic [4:0]  s13_day_nxt;
  logic [13:0] s13_year_nxt;
  always_comb begin
    s13_mi = '0;
    for (int k = 1; k < MONTHS; k++) begin
      s13_mi = s13_mi + 4'(s12_doy_r >= month_start(4'(k)));
    end
    s13_dd = s12_doy_r - month_start(s13_mi) + 9'd1;
    if (err_r[NSTAGE-2]) begin
      s13_year_nxt  = '0;
      s13_month_nxt = '0;
      s13_day_nxt   = '0;
    end else begin
      s13_year_nxt  = s12_year_r;
      s13_month_nxt = (s13_mi < 4'd10) ? s13_mi + 4'd3 : s13_mi - 4'd9;
      s13_day_nxt   = s13_dd[4:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s0_u_r   <= s0_u_nxt;
      err_r[0] <= s0_err_nxt;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (ctl.en[k]) begin
        err_r[k] <= err_r[k-1];
      end
    end
    if (ctl.en[1]) begin
      s1_q0_r <= s0_u_r[TS_W-1:DAY_LO_W];
      s1_lo_r <= s0_u_r[DAY_LO_W-1:0];
      s1_qe_r <= s1_qe_nxt;
    end
    if (ctl.en[2]) begin
      s2_q0_r <= s1_q0_r;
      s2_lo_r <= s1_lo_r;
      s2_qe_r <= s1_qe_r;
      s2_qd_r <= s2_qd_nxt;
    end
    if (ctl.en[3]) begin
      s3_days_r <= s3_days_nxt;
      s3_sod_r  <= s3_sod_nxt;
    end
    if (ctl.en[4]) begin
      s4_days_r  <= s3_days_r;
      s4_sod_r   <= s3_sod_r;
      s4_era_e_r <= s4_era_e_nxt;
      s4_hr_e_r  <= s4_hr_e_nxt;
    end
    if (ctl.en[5]) begin
      era_r[5]  <= s5_era_nxt;
      s5_doe_r  <= s5_doe_nxt;
      s5_hour_r <= s5_hour_nxt;
      s5_sos_r  <= s5_sos_nxt;
    end
    for (int k = 6; k <= NSTAGE - 3; k++) begin
      if (ctl.en[k]) begin
        era_r[k] <= era_r[k-1];
      end
    end
    if (ctl.en[6]) begin
      s6_doe_r    <= s5_doe_r;
      s6_hour_r   <= s5_hour_r;
      s6_sos_r    <= s5_sos_r;
      s6_cent_e_r <= s6_cent_e_nxt;
      s6_min_e_r  <= s6_min_e_nxt;
    end
    if (ctl.en[7]) begin
      cent_r[7] <= s7_cent_nxt;
      s7_doc_r  <= s7_doc_nxt;
      tod_r[7]  <= s7_tod_nxt;
    end
    for (int k = 8; k <= NSTAGE - 3; k++) begin
      if (ctl.en[k]) begin
        cent_r[k] <= cent_r[k-1];
      end
    end
    for (int k = 8; k < NSTAGE; k++) begin
      if (ctl.en[k]) begin
        tod_r[k] <= tod_r[k-1];
      end
    end
    if (ctl.en[8]) begin
      s8_doc_r   <= s7_doc_r;
      s8_blk_e_r <= s8_blk_e_nxt;
    end
    if (ctl.en[9]) begin
      blk_r[9] <= s9_blk_nxt;
      s9_dob_r <= s9_dob_nxt;
    end
    for (int k = 10; k <= NSTAGE - 3; k++) begin
      if (ctl.en[k]) begin
        blk_r[k] <= blk_r[k-1];
      end
    end
    if (ctl.en[10]) begin
      s10_dob_r   <= s9_dob_r;
      s10_yob_e_r <= s10_yob_e_nxt;
    end
    if (ctl.en[11]) begin
      s11_yob_r <= s11_yob_nxt;
      s11_doy_r <= s11_doy_nxt;
    end
    if (ctl.en[12]) begin
      s12_year_r <= s12_year_nxt;
      s12_doy_r  <= s12_doy_nxt;
    end
    if (ctl.en[13]) begin
      s13_year_r  <= s13_year_nxt;
      s13_month_r <= s13_month_nxt;
      s13_day_r   <= s13_day_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output beat; time of day is zeroed here for an out-of-range stamp
  // --------------------------------------------------------------------------
  tod_t tod_out;
  assign tod_out = err_r[NSTAGE-1] ? '0 : tod_r[NSTAGE-1];

  assign out_tdata = {tod_out.second, tod_out.minute, tod_out.hour,
                      s13_day_r, s13_month_r, s13_year_r};
  assign out_tuser = err_r[NSTAGE-1];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Any empty stage means the input side can move.
  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&ctl.vld) |-> in_tready)
    else $error("in_tready low with an empty stage");

  // A draining output frees the whole chain.
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while output drains");

  // In-range results carry a legal calendar date and time.
  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |->
      (s13_month_r >= 4'd1 && s13_month_r <= 4'd12 &&
       s13_day_r >= 5'd1 && s13_year_r >= 14'd1 && s13_year_r <= 14'd9999 &&
       tod_out.hour <= 5'd23 && tod_out.minute <= 6'd59 &&
       tod_out.second <= 6'd59))
    else $error("calendar field out of range");

endmodule

[src/esc_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// esc_pipe_ctrl: valid and load-enable control for the conversion pipeline
// Bubble-collapsing chain; a stage loads when empty or when it drains.
// ----------------------------------------------------------------------------
module esc_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output esc_pkg::pipe_ctl_t ctl
);
  import esc_pkg::*;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE:0]   rdy;

  always_comb begin
    rdy[NSTAGE] = out_tready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTAGE-1];
  assign ctl.en     = rdy[NSTAGE-1:0];
  assign ctl.vld    = vld_r;

endmodule
